### hw/rtl/ntfm_pkg.sv
// ----------------------------------------------------------------------------
// ntfm_pkg - nearest timestamp frame matcher shared definitions
// Table geometry, field widths and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ntfm_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int TIME_WIDTH  = 48;
  localparam int FRAME_LIMIT = 10;
  localparam int CAPACITY    = (FRAME_LIMIT < TABLE_DEPTH) ? FRAME_LIMIT : TABLE_DEPTH;

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int SLOT_W = 4;
  localparam int OUT_TIME_W = 48;

  // req_type codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // output tdata layout, lowest bit up
  localparam int OUT_DATA_W = 56;

  typedef struct packed {
    logic start;   // capture request, restart scan
    logic step;    // fold entry at scan index
    logic diff;    // form distances to neighbors
    logic commit;  // update table, load result register
  } ntfm_cmd_t;

  typedef struct packed {
    logic scan_last;
  } ntfm_sts_t;

endpackage

`default_nettype wire

### hw/rtl/nearest_timestamp_frame_matcher_unit.sv
// ----------------------------------------------------------------------------
// nearest_timestamp_frame_matcher_unit - timestamp table with nearest match
// Sequence: the accepted item runs a scan over the first CAPACITY table
//   slots, a distance step and a commit step; the commit waits while the
//   previous result is still held on the output.
// One item is in flight at a time; the next is accepted back in idle.
// A new input is taken while the previous result still waits on the output.
// Reset: asynchronous, active low; clears all valid bits and the FSM.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_timestamp_frame_matcher_unit
  import ntfm_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  wire [TIME_WIDTH-1:0] s_axis_tdata_i,   // [47:0] time_us
  input  wire                  s_axis_tuser_i,   // [0] req_type
  output logic                 m_axis_tvalid_o,
  input  wire                  m_axis_tready_i,
  // [3:0] slot, [51:4] matched_time_us, [52] accepted, [53] table_empty, [55:54] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  ntfm_cmd_t              cmd;
  ntfm_sts_t              sts;
  logic [SLOT_W-1:0]      slot;
  logic [OUT_TIME_W-1:0]  mtime;
  logic                   accepted;
  logic                   table_empty;

  ntfm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_ready_i (m_axis_tready_i),
    .m_valid_o (m_axis_tvalid_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ntfm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .req_type_i     (s_axis_tuser_i),
    .time_us_i      (s_axis_tdata_i),
    .sts_o          (sts),
    .slot_o         (slot),
    .matched_time_o (mtime),
    .accepted_o     (accepted),
    .table_empty_o  (table_empty)
  );

  assign m_axis_tdata_o = {2'b00, table_empty, accepted, mtime, slot};

  // one item in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second item accepted during scan");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> m_axis_tvalid_o)
    else $error("committed result not presented");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(accepted && table_empty))
    else $error("accepted and table_empty both set");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result overwritten before transfer");

endmodule

`default_nettype wire

### hw/rtl/ntfm_ctrl.sv
// ----------------------------------------------------------------------------
// ntfm_ctrl - sequencer for the frame matcher
// Accepts one request, steps the datapath scan, forms the neighbor distances,
// then commits the result into the output register once that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module ntfm_ctrl
  import ntfm_pkg::*;
(
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            s_valid_i,
  output logic           s_ready_o,
  input  wire            m_ready_i,
  output logic           m_valid_o,
  input  wire ntfm_sts_t sts_i,
  output ntfm_cmd_t      cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DIFF = 2'd2;
  localparam logic [1:0] ST_RES  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_RES;
      end
      ST_RES: begin
        // wait for the previous result to drain
        if (!out_valid_q || m_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o = out_valid_q;

endmodule

`default_nettype wire

### hw/rtl/ntfm_dp.sv
// ----------------------------------------------------------------------------
// ntfm_dp - frame matcher datapath
// Timestamp table with valid bits, a one-entry-per-cycle scan that tracks
// newest, oldest, duplicate, free slot and both query neighbors, and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ntfm_dp
  import ntfm_pkg::*;
(
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire ntfm_cmd_t         cmd_i,
  input  wire                    req_type_i,
  input  wire [TIME_WIDTH-1:0]   time_us_i,
  output ntfm_sts_t              sts_o,
  output logic [SLOT_W-1:0]      slot_o,
  output logic [OUT_TIME_W-1:0]  matched_time_o,
  output logic                   accepted_o,
  output logic                   table_empty_o
);

  logic [TIME_WIDTH-1:0] mem_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;

  logic                  req_q;
  logic [TIME_WIDTH-1:0] t_q;
  logic [IDX_W-1:0]      idx_q;
  logic [CNT_W-1:0]      cnt_q;

  logic                  max_vld_q, min_vld_q, dup_vld_q, free_vld_q, low_vld_q, prev_vld_q;
  logic [IDX_W-1:0]      max_idx_q, min_idx_q, dup_idx_q, free_idx_q, low_idx_q, prev_idx_q;
  logic [TIME_WIDTH-1:0] max_time_q, min_time_q, low_time_q, prev_time_q;
  logic [TIME_WIDTH-1:0] dprev_q, dlow_q;

  logic [TIME_WIDTH-1:0] ent_q;
  logic                  ent_vld;

  assign ent_vld = valid_q[idx_q];
  assign sts_o.scan_last = (idx_q == IDX_W'(CAPACITY - 1));

  // registered table read, fetched one entry ahead of the scan index
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      ent_q <= mem_q[0];
    end else if (cmd_i.step) begin
      ent_q <= mem_q[idx_q + IDX_W'(1)];
    end
  end

  // scan registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q      <= req_type_i;
      t_q        <= time_us_i;
      idx_q      <= '0;
      cnt_q      <= '0;
      max_vld_q  <= 1'b0;
      min_vld_q  <= 1'b0;
      dup_vld_q  <= 1'b0;
      free_vld_q <= 1'b0;
      low_vld_q  <= 1'b0;
      prev_vld_q <= 1'b0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + IDX_W'(1);
      if (ent_vld) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (!max_vld_q || ent_q > max_time_q) begin
          max_vld_q  <= 1'b1;
          max_idx_q  <= idx_q;
          max_time_q <= ent_q;
        end
        if (!min_vld_q || ent_q < min_time_q) begin
          min_vld_q  <= 1'b1;
          min_idx_q  <= idx_q;
          min_time_q <= ent_q;
        end
        if (!dup_vld_q && ent_q == t_q) begin
          dup_vld_q <= 1'b1;
          dup_idx_q <= idx_q;
        end
        if (ent_q >= t_q) begin
          if (!low_vld_q || ent_q < low_time_q) begin
            low_vld_q  <= 1'b1;
            low_idx_q  <= idx_q;
            low_time_q <= ent_q;
          end
        end else if (!prev_vld_q || ent_q > prev_time_q) begin
          prev_vld_q  <= 1'b1;
          prev_idx_q  <= idx_q;
          prev_time_q <= ent_q;
        end
      end else if (!free_vld_q) begin
        free_vld_q <= 1'b1;
        free_idx_q <= idx_q;
      end
    end else if (cmd_i.diff) begin
      dprev_q <= t_q - prev_time_q;
      dlow_q  <= low_time_q - t_q;
    end
  end

  // insert decision
  logic             newest_dup, full, dup_alive, do_store;
  logic [IDX_W-1:0] tgt_idx;

  assign newest_dup = max_vld_q && (max_time_q == t_q);
  assign full       = (cnt_q >= CNT_W'(CAPACITY));
  // a duplicate that is also the evicted oldest entry no longer counts
  assign dup_alive  = dup_vld_q && !(full && dup_idx_q == min_idx_q);
  assign tgt_idx    = full ? min_idx_q : free_idx_q;
  assign do_store   = cmd_i.commit && (req_q == REQ_INSERT) && !newest_dup && !dup_alive;

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.commit && req_q == REQ_INSERT && !newest_dup) begin
      if (full) begin
        valid_d[min_idx_q] = 1'b0;
      end
      if (!dup_alive) begin
        valid_d[tgt_idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_store) begin
      mem_q[tgt_idx] <= t_q;
    end
  end

  // result selection
  logic                  pick_prev;
  logic [IDX_W-1:0]      res_idx;
  logic [TIME_WIDTH-1:0] res_time;
  logic                  res_acc, res_empty;

  always_comb begin
    pick_prev = 1'b0;
    res_idx   = '0;
    res_time  = t_q;
    res_acc   = 1'b0;
    res_empty = 1'b0;
    if (req_q == REQ_QUERY) begin
      if (!low_vld_q) begin
        pick_prev = 1'b1;
      end else if (!prev_vld_q) begin
        pick_prev = 1'b0;
      end else begin
        pick_prev = (dprev_q < dlow_q);
      end
      if (!low_vld_q && !prev_vld_q) begin
        res_empty = 1'b1;
        res_time  = '0;
      end else if (pick_prev) begin
        res_idx  = prev_idx_q;
        res_time = prev_time_q;
      end else begin
        res_idx  = low_idx_q;
        res_time = low_time_q;
      end
    end else if (newest_dup) begin
      res_idx = max_idx_q;
    end else if (dup_alive) begin
      res_idx = dup_idx_q;
    end else begin
      res_idx = tgt_idx;
      res_acc = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      slot_o         <= SLOT_W'(res_idx);
      matched_time_o <= OUT_TIME_W'(res_time);
      accepted_o     <= res_acc;
      table_empty_o  <= res_empty;
    end
  end

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - frame timestamp matcher testbench
// Sends insert and query transactions and checks each result against a
// behavioral table copy or a typed row's fixed value. A short directed table
// goes first, then random traffic that follows a running frame clock. Stalls
// on both sides come in random bursts, except in two stretches of the random run.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import ntfm_pkg::*;

  typedef struct packed {
    logic [OUT_DATA_W-SLOT_W-OUT_TIME_W-3:0] pad;
    logic                                    table_empty;
    logic                                    accepted;
    logic [OUT_TIME_W-1:0]                   matched_us;
    logic [SLOT_W-1:0]                       slot;
  } frame_match_t;

  typedef struct {
    logic                  req;
    logic [TIME_WIDTH-1:0] stamp;
    bit                    typed;
    frame_match_t          want;
  } stim_row_t;

  localparam logic [TIME_WIDTH-1:0] MAX_US  = {TIME_WIDTH{1'b1}};
  localparam logic [TIME_WIDTH-1:0] HALF_US = {1'b1, {(TIME_WIDTH-1){1'b0}}};
  localparam int RANDOM_ITEMS = 650;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [TIME_WIDTH-1:0]  s_axis_tdata_i;
  logic                   s_axis_tuser_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_DATA_W-1:0]  m_axis_tdata_o;

  // typed expectation travels beside the transaction it belongs to
  bit                     row_typed;
  frame_match_t           row_want;
  bit                     idling;

  logic [TIME_WIDTH-1:0]  key_time [CAPACITY];
  bit                     key_live [CAPACITY];
  frame_match_t           expected_matches[$];
  stim_row_t              directed_rows[$];
  logic [TIME_WIDTH-1:0]  frame_clock;
  int                     fault_count;
  int                     shown_count;

  nearest_timestamp_frame_matcher_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic frame_match_t outcome(int slot, logic [TIME_WIDTH-1:0] mt,
                                           bit acc, bit empty);
    frame_match_t r;
    r             = '0;
    r.slot        = slot[SLOT_W-1:0];
    r.matched_us  = mt;
    r.accepted    = acc;
    r.table_empty = empty;
    return r;
  endfunction

  // Updates the table copy and returns the result of one transaction.
  function automatic frame_match_t predict_frame(logic req, logic [TIME_WIDTH-1:0] t);
    frame_match_t r;
    int newest, oldest, dup, free_idx, live_cnt, low, prev, pick;
    r = '0;
    if (req == REQ_INSERT) begin
      newest = -1;
      r.matched_us = t;
      for (int i = 0; i < CAPACITY; i++)
        if (key_live[i] && (newest < 0 || key_time[i] > key_time[newest])) newest = i;
      if (newest >= 0 && key_time[newest] == t) begin
        r.slot = newest[SLOT_W-1:0];
      end else begin
        live_cnt = 0;
        oldest   = -1;
        for (int i = 0; i < CAPACITY; i++) begin
          if (key_live[i]) begin
            live_cnt++;
            if (oldest < 0 || key_time[i] < key_time[oldest]) oldest = i;
          end
        end
        if (live_cnt >= CAPACITY && oldest >= 0) key_live[oldest] = 1'b0;
        dup      = -1;
        free_idx = -1;
        for (int i = 0; i < CAPACITY; i++) begin
          if (key_live[i] && key_time[i] == t && dup < 0) dup = i;
          if (!key_live[i] && free_idx < 0) free_idx = i;
        end
        if (dup >= 0) begin
          r.slot = dup[SLOT_W-1:0];
        end else if (free_idx >= 0) begin
          key_live[free_idx] = 1'b1;
          key_time[free_idx] = t;
          r.slot             = free_idx[SLOT_W-1:0];
          r.accepted         = 1'b1;
        end
      end
    end else begin
      low  = -1;
      prev = -1;
      for (int i = 0; i < CAPACITY; i++) begin
        if (!key_live[i]) continue;
        if (key_time[i] >= t) begin
          if (low < 0 || key_time[i] < key_time[low]) low = i;
        end else begin
          if (prev < 0 || key_time[i] > key_time[prev]) prev = i;
        end
      end
      if (low < 0) pick = prev;
      else if (prev < 0) pick = low;
      else pick = ((t - key_time[prev]) < (key_time[low] - t)) ? prev : low;
      if (pick < 0) begin
        r.table_empty = 1'b1;
      end else begin
        r.slot       = pick[SLOT_W-1:0];
        r.matched_us = key_time[pick];
      end
    end
    return r;
  endfunction

  task automatic add_row(logic req, logic [TIME_WIDTH-1:0] t, bit typed,
                         frame_match_t want);
    stim_row_t row;
    row.req   = req;
    row.stamp = t;
    row.typed = typed;
    row.want  = want;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Mostly frame-rate traffic around a running clock, with stored-key hits,
  // midpoints between keys and full-range noise mixed in.
  task automatic pick_random(output logic req, output logic [TIME_WIDTH-1:0] t);
    int kind, a, b;
    int live[$];
    logic [TIME_WIDTH-1:0] lo, hi;
    for (int i = 0; i < CAPACITY; i++)
      if (key_live[i]) live.insert(live.size(), i);
    kind = $urandom_range(0, 99);
    req  = REQ_QUERY;
    t    = frame_clock;
    if (kind < 35) begin
      if ($urandom_range(0, 99) == 0) frame_clock = {16'($urandom()), 32'($urandom())};
      else frame_clock = frame_clock + $urandom_range(1, 40000);
      req = REQ_INSERT;
      t   = frame_clock;
    end else if (kind < 40) begin
      req = REQ_INSERT;
    end else if (kind < 46) begin
      req = REQ_INSERT;
      if (live.size() > 0 && $urandom_range(0, 1) == 1)
        t = key_time[live[$urandom_range(0, live.size() - 1)]];
      else
        t = frame_clock - $urandom_range(0, 100000);
    end else if (kind < 78) begin
      t = frame_clock + $urandom_range(0, 50000) - $urandom_range(0, 300000);
    end else if (kind < 86) begin
      if (live.size() >= 2) begin
        a  = live[$urandom_range(0, live.size() - 1)];
        b  = live[$urandom_range(0, live.size() - 1)];
        lo = (key_time[a] < key_time[b]) ? key_time[a] : key_time[b];
        hi = (key_time[a] < key_time[b]) ? key_time[b] : key_time[a];
        t  = lo + (hi - lo) / 2;
      end
    end else if (kind < 94) begin
      req = $urandom_range(0, 1) ? REQ_QUERY : REQ_INSERT;
      t   = {16'($urandom()), 32'($urandom())};
    end else if (live.size() > 0) begin
      t = key_time[live[$urandom_range(0, live.size() - 1)]];
    end
  endtask

  task automatic drive_item(logic req, logic [TIME_WIDTH-1:0] t, bit typed,
                            frame_match_t want, int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= {16'($urandom()), 32'($urandom())};
      s_axis_tuser_i  <= 1'($urandom_range(0, 1));
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= t;
    s_axis_tuser_i  <= req;
    row_typed       <= typed;
    row_want        <= want;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk_i);
  endtask

  function automatic int pick_gap();
    return (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
  endfunction

  // result side stall bursts
  initial begin
    m_axis_tready_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (idling && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : scoreboard
    frame_match_t got, want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        want = predict_frame(s_axis_tuser_i, s_axis_tdata_i);
        if (row_typed) want = row_want;
        expected_matches.insert(expected_matches.size(), want);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o;
        if (expected_matches.size() == 0) begin
          fault_count++;
          if (shown_count < 10) begin
            shown_count++;
            $display("unexpected result transaction: %h", got);
          end
        end else begin
          want = expected_matches.pop_front();
          if (got !== want) begin
            fault_count++;
            if (shown_count < 10) begin
              shown_count++;
              $display("result mismatch: slot %0d/%0d time %h/%h acc %b/%b empty %b/%b pad %b/%b",
                       want.slot, got.slot, want.matched_us, got.matched_us,
                       want.accepted, got.accepted, want.table_empty, got.table_empty,
                       want.pad, got.pad);
            end
          end
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic                  req;
    logic [TIME_WIDTH-1:0] t;
    fault_count     = 0;
    shown_count     = 0;
    idling          = 1'b1;
    frame_clock     = {16'($urandom_range(0, 255)), 32'($urandom())};
    for (int i = 0; i < CAPACITY; i++) key_live[i] = 1'b0;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= REQ_INSERT;
    row_typed       <= 1'b0;
    row_want        <= '0;

    // empty table, extremes, duplicates, ties, fill and eviction
    add_row(REQ_QUERY,  '0,         1, outcome(0, '0, 0, 1));
    add_row(REQ_QUERY,  MAX_US,     1, outcome(0, '0, 0, 1));
    add_row(REQ_INSERT, '0,         1, outcome(0, '0, 1, 0));
    add_row(REQ_INSERT, '0,         1, outcome(0, '0, 0, 0));
    add_row(REQ_INSERT, MAX_US,     1, outcome(1, MAX_US, 1, 0));
    add_row(REQ_QUERY,  '0,         1, outcome(0, '0, 0, 0));
    add_row(REQ_QUERY,  MAX_US,     1, outcome(1, MAX_US, 0, 0));
    add_row(REQ_QUERY,  HALF_US,    0, '0);
    add_row(REQ_INSERT, 48'd1000,   1, outcome(2, 48'd1000, 1, 0));
    add_row(REQ_INSERT, 48'd2000,   1, outcome(3, 48'd2000, 1, 0));
    add_row(REQ_QUERY,  48'd1500,   0, '0);
    add_row(REQ_QUERY,  48'd1499,   0, '0);
    add_row(REQ_INSERT, 48'd1000,   1, outcome(2, 48'd1000, 0, 0));
    for (int k = 3; k <= 8; k++) add_row(REQ_INSERT, 48'(k * 1000), 0, '0);
    add_row(REQ_INSERT, 48'd8000,   0, '0);  // older key while full
    add_row(REQ_INSERT, 48'd500,    0, '0);
    add_row(REQ_INSERT, 48'd500,    0, '0);  // evicted, then stored again
    add_row(REQ_INSERT, 48'd12345,  0, '0);
    add_row(REQ_QUERY,  48'd2999,   0, '0);
    add_row(REQ_QUERY,  48'd5500,   0, '0);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[k])
      drive_item(directed_rows[k].req, directed_rows[k].stamp, directed_rows[k].typed,
                 directed_rows[k].want, pick_gap());
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idling = !((n >= 200 && n < 300) || n >= RANDOM_ITEMS - 100);
      if (n == RANDOM_ITEMS / 2) drain_results();
      pick_random(req, t);
      drive_item(req, t, 1'b0, '0, pick_gap());
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    fault_count += expected_matches.size();
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
